/* rtl/bbwm_pkg.sv */
package bbwm_pkg;

  // samples per pixel and bits per sample
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned WORD_W = NUM_CH * PIX_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [2:0]  RADIUS_RST = 3'd1;
  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [11:0] HEIGHT_RST = 12'd1024;

  localparam logic MODE_PIXEL = 1'b0;

  // shared read control of the row lanes
  typedef struct packed {
    logic rd_en;
    logic clr;
  } lane_ctrl_t;

endpackage

/* rtl/box_blur_window_mean.sv */
// Box blur with a shrinking window over an RGB raster stream.
// Input channel: in_valid_i / in_stall_o carry one word per pixel (mode 0)
// or a drain tick (mode 1). Output channel: out_valid_o / out_stall_i carry
// the window mean of one pixel plus frame_end on the last pixel of a frame.
// Configuration: cfg_we_i with cfg_idx_i/cfg_data_i writes a register and
// restarts the frame; write only while the block is idle.
// Each ring row of the line buffer sits in its own lane with a private
// memory bank, so all rows of a window column are read in the same cycle.
// Per word: accept, check, column reads over the C window columns (up to
// 2*MAX_RADIUS+1) and a drain step, merge of all 2*MAX_RADIUS+2 lanes,
// divide (one quotient bit per cycle, then done), then the load into the
// output register. A word that yields no result frees the input after the
// check. No new word is taken until the last one is done and the block idle.
// A finished result waits in the output register while the receiver
// stalls; the next result then waits in the output step, and no new word
// is taken before it is loaded.
// Reset: registers take radius 1, width 1024, height 1024; counters clear.
// The line buffer has no reset: only pixels of the current frame are read.
module box_blur_window_mean #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_RADIUS = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bbwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bbwm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              frame_end_o
);

  localparam int unsigned RING  = 2 * MAX_RADIUS + 2;
  localparam int unsigned WIN   = 2 * MAX_RADIUS + 1;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned SLW   = $clog2(RING);
  localparam int unsigned KW    = $clog2(RING);
  localparam int unsigned NW    = $clog2(WIN + 1);
  localparam int unsigned CNT_W = $clog2(WIN * WIN + 1);
  localparam int unsigned ACC_W = $clog2(WIN * 255 + 1);
  localparam int unsigned SUM_W = $clog2(WIN * WIN * 255 + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state_q, state_d;

  // configuration registers
  logic [2:0]  radius_q;
  logic [10:0] width_q;
  logic [11:0] height_q;
  logic [2:0]  r_eff;
  logic [10:0] w_eff;
  logic [11:0] h_eff;

  // stream positions
  logic [CW-1:0]  in_col_q, out_col_q;
  logic [11:0]    in_row_q, out_row_q;
  logic [SLW-1:0] in_slot_q, out_slot_q;

  // window of the current output
  logic [CW-1:0]  first_c_q, last_c_q, x_q;
  logic [RING-1:0] en_q;
  logic [CNT_W-1:0] cnt_q;
  logic [KW-1:0]  k_q;
  logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [SUM_W-1:0] sum_r_d, sum_g_d, sum_b_d;

  logic           out_valid_q;
  logic [7:0]     red_q, green_q, blue_q;
  logic           frame_end_q;

  logic           accept;
  logic           input_done;
  logic           do_write;
  logic           out_load;
  logic           last_px;
  logic           ready;
  bbwm_pkg::lane_ctrl_t lane_ctrl;
  logic           div_start;
  logic           div_done;
  logic [SUM_W-1:0] quot_r, quot_g, quot_b;

  logic [12:0]    row_hi, col_hi;
  logic [11:0]    last_r, first_r;
  logic [CW-1:0]  last_c, first_c;
  logic [NW-1:0]  rows, cols;
  logic [SLW:0]   back;
  logic [SLW-1:0] fslot;
  logic [RING-1:0] en_d;

  logic [ACC_W-1:0] acc_r [RING];
  logic [ACC_W-1:0] acc_g [RING];
  logic [ACC_W-1:0] acc_b [RING];

  // clamp registers to their working ranges
  assign r_eff = (radius_q > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_q;
  always_comb begin
    if (width_q == '0) begin
      w_eff = 11'd1;
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
  end
  assign h_eff = (height_q == '0) ? 12'd1 : height_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign input_done = (in_row_q >= h_eff);
  assign do_write   = accept && (mode_i == bbwm_pkg::MODE_PIXEL) && !input_done;

  // window bounds, cut to the frame
  always_comb begin
    row_hi  = 13'(out_row_q) + 13'(r_eff);
    col_hi  = 13'(out_col_q) + 13'(r_eff);
    last_r  = (row_hi > 13'(h_eff - 12'd1)) ? (h_eff - 12'd1) : row_hi[11:0];
    last_c  = (col_hi > 13'(w_eff - 11'd1)) ? CW'(w_eff - 11'd1) : CW'(col_hi);
    first_r = (out_row_q > 12'(r_eff)) ? (out_row_q - 12'(r_eff)) : 12'd0;
    first_c = (out_col_q > CW'(r_eff)) ? (out_col_q - CW'(r_eff)) : '0;
    rows    = NW'(last_r - first_r) + NW'(1);
    cols    = NW'(last_c - first_c) + NW'(1);
    back    = (SLW + 1)'(out_row_q - first_r);
    if ({1'b0, out_slot_q} >= back) begin
      fslot = SLW'({1'b0, out_slot_q} - back);
    end else begin
      fslot = SLW'({1'b0, out_slot_q} + (SLW + 1)'(RING) - back);
    end
  end

  // a lane takes part when its ring row lies inside the window rows
  always_comb begin
    for (int k = 0; k < RING; k++) begin
      logic [SLW:0] off;
      if (SLW'(k) >= fslot) begin
        off = (SLW + 1)'(k) - {1'b0, fslot};
      end else begin
        off = (SLW + 1)'(k + RING) - {1'b0, fslot};
      end
      en_d[k] = (off < (SLW + 1)'(rows));
    end
  end

  // output is due once every pixel of its window is in
  assign ready = (out_row_q < h_eff) &&
                 (input_done || (in_row_q > last_r) ||
                  ((in_row_q == last_r) && (in_col_q > last_c)));

  assign last_px  = (out_row_q == h_eff - 12'd1) && (12'(out_col_q) == 12'(w_eff) - 12'd1);
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CHECK;
      S_CHECK: state_d = ready ? S_READ : S_IDLE;
      S_READ:  if (x_q == last_c_q) state_d = S_DRAIN;
      S_DRAIN: state_d = S_MERGE;
      S_MERGE: if (k_q == KW'(RING - 1)) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign lane_ctrl.rd_en = (state_q == S_READ);
  assign lane_ctrl.clr   = (state_q == S_CHECK);
  assign div_start       = (state_q == S_MERGE) && (k_q == KW'(RING - 1));

  // running sums including the lane merged this cycle
  assign sum_r_d = sum_r_q + SUM_W'(acc_r[k_q]);
  assign sum_g_d = sum_g_q + SUM_W'(acc_g[k_q]);
  assign sum_b_d = sum_b_q + SUM_W'(acc_b[k_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= bbwm_pkg::RADIUS_RST;
      width_q     <= bbwm_pkg::WIDTH_RST;
      height_q    <= bbwm_pkg::HEIGHT_RST;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i == bbwm_pkg::REG_RADIUS || cfg_idx_i == bbwm_pkg::REG_WIDTH ||
                       cfg_idx_i == bbwm_pkg::REG_HEIGHT)) begin
        case (cfg_idx_i)
          bbwm_pkg::REG_RADIUS: radius_q <= cfg_data_i[2:0];
          bbwm_pkg::REG_WIDTH:  width_q  <= cfg_data_i[10:0];
          default:              height_q <= cfg_data_i;
        endcase
        // restart the frame
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
      end else begin
        if (do_write) begin
          if (12'(in_col_q) + 12'd1 >= 12'(w_eff)) begin
            in_col_q  <= '0;
            in_row_q  <= in_row_q + 12'd1;
            in_slot_q <= (in_slot_q == SLW'(RING - 1)) ? '0 : in_slot_q + 1'b1;
          end else begin
            in_col_q <= in_col_q + 1'b1;
          end
        end
        if (out_load) begin
          if (last_px) begin
            in_col_q   <= '0;
            in_row_q   <= '0;
            in_slot_q  <= '0;
            out_col_q  <= '0;
            out_row_q  <= '0;
            out_slot_q <= '0;
          end else if (12'(out_col_q) + 12'd1 >= 12'(w_eff)) begin
            out_col_q  <= '0;
            out_row_q  <= out_row_q + 12'd1;
            out_slot_q <= (out_slot_q == SLW'(RING - 1)) ? '0 : out_slot_q + 1'b1;
          end else begin
            out_col_q <= out_col_q + 1'b1;
          end
        end
      end
    end
  end

  // window setup, column sweep, lane merge and output register load
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CHECK: begin
        first_c_q <= first_c;
        last_c_q  <= last_c;
        x_q       <= first_c;
        en_q      <= en_d;
        cnt_q     <= CNT_W'(rows) * CNT_W'(cols);
        k_q       <= '0;
        sum_r_q   <= '0;
        sum_g_q   <= '0;
        sum_b_q   <= '0;
      end
      S_READ: x_q <= x_q + 1'b1;
      S_MERGE: begin
        sum_r_q <= sum_r_d;
        sum_g_q <= sum_g_d;
        sum_b_q <= sum_b_d;
        k_q     <= k_q + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      red_q       <= quot_r[7:0];
      green_q     <= quot_g[7:0];
      blue_q      <= quot_b[7:0];
      frame_end_q <= last_px;
    end
  end

  for (genvar g = 0; g < RING; g++) begin : g_lane
    bbwm_lane #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .ACC_W (ACC_W)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (do_write && (in_slot_q == SLW'(g))),
      .wr_addr_i (in_col_q),
      .wr_data_i ({red_in_i, green_in_i, blue_in_i}),
      .ctrl_i    (lane_ctrl),
      .rd_addr_i (x_q),
      .en_i      (en_q[g]),
      .acc_r_o   (acc_r[g]),
      .acc_g_o   (acc_g[g]),
      .acc_b_o   (acc_b[g])
    );
  end

  bbwm_div #(.N(SUM_W), .DW(CNT_W)) u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .dividend_i (sum_r_d), .divisor_i (cnt_q), .done_o (div_done), .quot_o (quot_r)
  );

  bbwm_div #(.N(SUM_W), .DW(CNT_W)) u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .dividend_i (sum_g_d), .divisor_i (cnt_q), .done_o (), .quot_o (quot_g)
  );

  bbwm_div #(.N(SUM_W), .DW(CNT_W)) u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .dividend_i (sum_b_d), .divisor_i (cnt_q), .done_o (), .quot_o (quot_b)
  );

  assign out_valid_o = out_valid_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign frame_end_o = frame_end_q;

  // a new result only comes from the output load step
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result appeared outside the output step");

  // divider ends the divide step
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |=> state_q == S_OUT)
    else $error("divide step did not finish");

  // divisor never zero once the window is set up
  a_cnt_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> cnt_q != '0)
    else $error("empty window");

  // column sweep stays inside the window
  a_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (x_q >= first_c_q && x_q <= last_c_q))
    else $error("column sweep left the window");

endmodule

/* rtl/bbwm_lane.sv */
module bbwm_lane #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned ACC_W = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [bbwm_pkg::WORD_W-1:0]  wr_data_i,
  input  bbwm_pkg::lane_ctrl_t         ctrl_i,
  input  logic [AW-1:0]                rd_addr_i,
  input  logic                         en_i,
  output logic [ACC_W-1:0]             acc_r_o,
  output logic [ACC_W-1:0]             acc_g_o,
  output logic [ACC_W-1:0]             acc_b_o
);

  logic [bbwm_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bbwm_pkg::WORD_W-1:0] rd_data_q;
  logic                        rd_valid_q;
  logic [ACC_W-1:0]            acc_r_q, acc_g_q, acc_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= ctrl_i.rd_en;
    end
  end

  // add one column sample of this row per read while the lane is enabled
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (rd_valid_q && en_i) begin
      acc_r_q <= acc_r_q + ACC_W'(rd_data_q[23:16]);
      acc_g_q <= acc_g_q + ACC_W'(rd_data_q[15:8]);
      acc_b_q <= acc_b_q + ACC_W'(rd_data_q[7:0]);
    end
  end

  assign acc_r_o = acc_r_q;
  assign acc_g_o = acc_g_q;
  assign acc_b_o = acc_b_q;

endmodule

/* rtl/bbwm_div.sv */
module bbwm_div #(
  parameter int unsigned N  = 15,
  parameter int unsigned DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [N-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [N-1:0]  quot_o
);

  localparam int unsigned SW = $clog2(N);

  logic          busy_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [DW-1:0] div_q;
  logic [DW-1:0] rem_q;
  logic [N-1:0]  quo_q;
  logic [DW:0]   trial;
  logic          fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[N-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == SW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
      quo_q <= {quo_q[N-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
